>>> sv/sbc_pkg.sv
// Shared types, constants and round functions for the SHA-256 block compressor.
// No dependencies; every other file of the block imports this package.
package sbc_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS  = 64;
    localparam int unsigned CHAIN_WORDS = 8;
    localparam int unsigned POS_W       = $clog2(BLOCK_WORDS);
    localparam int unsigned ROUND_W     = $clog2(NUM_ROUNDS);
    localparam int unsigned CHAIN_IDX_W = $clog2(CHAIN_WORDS);
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned COUNT_W     = 64;

    localparam logic [POS_W-1:0]     LAST_POS   = POS_W'(BLOCK_WORDS - 1);
    localparam logic [ROUND_W-1:0]   LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);
    localparam logic [CFG_IDX_W-1:0] NUM_INIT   = CFG_IDX_W'(CHAIN_WORDS);
    localparam logic [COUNT_W-1:0]   BLOCK_BYTES = COUNT_W'(64);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0] chain_t;
    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_words_t;

    // One collected block as handed from the front to the back.
    typedef struct packed {
        logic         restart;
        chain_t       init;
        block_words_t words;
    } block_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_FINAL
    } back_state_t;

    // Standard initial hash value, word 0 at index 0.
    localparam chain_t IV_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

>>> sv/sbc_if.sv
// Channel interfaces of the SHA-256 block compressor: message in, digest out,
// configuration writes. Depends on sbc_pkg for field widths.
interface sbc_msg_if import sbc_pkg::*;;
    logic  valid;
    logic  ready;
    word_t message_word;
    logic  start_message;

    modport source (output valid, output message_word, output start_message, input ready);
    modport sink   (input valid, input message_word, input start_message, output ready);
endinterface

interface sbc_digest_if import sbc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [63:0]        digest_words_0_1;
    logic [63:0]        digest_words_2_3;
    logic [63:0]        digest_words_4_5;
    logic [63:0]        digest_words_6_7;
    logic [COUNT_W-1:0] bytes_hashed;

    modport source (output valid, output digest_words_0_1, output digest_words_2_3,
                    output digest_words_4_5, output digest_words_6_7,
                    output bytes_hashed, input ready);
    modport sink   (input valid, input digest_words_0_1, input digest_words_2_3,
                    input digest_words_4_5, input digest_words_6_7,
                    input bytes_hashed, output ready);
endinterface

interface sbc_cfg_if import sbc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    word_t                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/sbc_front.sv
// Front part: init-word registers, word collection into 16-word blocks and
// start handling. Depends on sbc_pkg and the channel interfaces in sbc_if.sv.
module sbc_front import sbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sbc_msg_if.sink      msg_in,
    sbc_cfg_if.sink      cfg,
    input  logic         q_ready,
    output logic         push_valid,
    output block_t       push_block
);

    chain_t                     init_reg, init_next;
    chain_t                     snap_reg, snap_next;
    logic [BLOCK_WORDS-2:0][WORD_W-1:0] buf_reg, buf_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       restart_reg, restart_next;
    logic [POS_W-1:0]           eff_pos;
    logic                       accept;
    logic                       last_word;

    assign cfg.ready    = 1'b1;
    // Only the 16th word needs room in the queue.
    assign msg_in.ready = (pos_reg != LAST_POS) || q_ready;
    assign accept       = msg_in.valid && msg_in.ready;
    // A start drops the partial block: the current word becomes word 0.
    assign eff_pos      = msg_in.start_message ? '0 : pos_reg;
    assign last_word    = (eff_pos == LAST_POS);

    always_comb
    begin
        init_next    = init_reg;
        snap_next    = snap_reg;
        buf_next     = buf_reg;
        pos_next     = pos_reg;
        restart_next = restart_reg;

        if (cfg.valid && (cfg.index < NUM_INIT))
        begin
            init_next[cfg.index[CHAIN_IDX_W-1:0]] = cfg.data;
        end

        if (accept)
        begin
            if (last_word)
            begin
                pos_next     = '0;
                restart_next = 1'b0;
            end
            else
            begin
                buf_next[eff_pos] = msg_in.message_word;
                pos_next          = eff_pos + 1'b1;
                if (msg_in.start_message)
                begin
                    // Capture the init words now; later writes must not leak in.
                    snap_next    = init_reg;
                    restart_next = 1'b1;
                end
            end
        end
    end

    assign push_valid         = accept && last_word;
    assign push_block.restart = restart_reg;
    assign push_block.init    = snap_reg;
    assign push_block.words   = {msg_in.message_word, buf_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg    <= IV_INIT;
            pos_reg     <= '0;
            restart_reg <= 1'b0;
        end
        else
        begin
            init_reg    <= init_next;
            pos_reg     <= pos_next;
            restart_reg <= restart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        buf_reg  <= buf_next;
    end

endmodule

>>> sv/sbc_queue.sv
// One-entry block queue between the front and the back of the compressor.
// Depends on sbc_pkg for the block record type.
module sbc_queue import sbc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    input  block_t push_block,
    output logic   push_ready,
    output logic   pop_valid,
    input  logic   pop_ready,
    output block_t pop_block
);

    logic   full_reg, full_next;
    block_t entry_reg, entry_next;

    assign push_ready = !full_reg;
    assign pop_valid  = full_reg;
    assign pop_block  = entry_reg;

    always_comb
    begin
        full_next  = full_reg;
        entry_next = entry_reg;
        if (push_valid && !full_reg)
        begin
            full_next  = 1'b1;
            entry_next = push_block;
        end
        else if (pop_ready && full_reg)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> sv/sbc_back.sv
// Back part: schedule expansion, 64 rounds at one per cycle, chaining add,
// byte count and the output register. Depends on sbc_pkg and sbc_if.sv.
module sbc_back import sbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         blk_valid,
    output logic         blk_ready,
    input  block_t       blk,
    sbc_digest_if.source digest_out
);

    back_state_t          state_reg, state_next;
    logic [ROUND_W-1:0]   rnd_reg, rnd_next;
    chain_t               chain_reg, chain_next;
    chain_t               v_reg, v_next;
    block_words_t         w_reg, w_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    chain_t               out_chain_reg, out_chain_next;
    logic [COUNT_W-1:0]   out_total_reg, out_total_next;

    chain_t               base;
    chain_t               chain_sum;
    chain_t               v_round;
    word_t                t1;
    word_t                t2;
    word_t                w_new;

    assign base = blk.restart ? blk.init : chain_reg;

    always_comb
    begin
        t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
           + ROUND_K[rnd_reg] + w_reg[0];
        t2 = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);
        v_round[0] = t1 + t2;
        v_round[1] = v_reg[0];
        v_round[2] = v_reg[1];
        v_round[3] = v_reg[2];
        v_round[4] = v_reg[3] + t1;
        v_round[5] = v_reg[4];
        v_round[6] = v_reg[5];
        v_round[7] = v_reg[6];
        w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
        for (int i = 0; i < CHAIN_WORDS; i++)
        begin
            chain_sum[i] = chain_reg[i] + v_reg[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        chain_next     = chain_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !digest_out.ready;
        out_chain_next = out_chain_reg;
        out_total_next = out_total_reg;
        blk_ready      = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                blk_ready = 1'b1;
                if (blk_valid)
                begin
                    chain_next = base;
                    v_next     = base;
                    w_next     = blk.words;
                    total_next = blk.restart ? '0 : total_reg;
                    rnd_next   = '0;
                    state_next = BK_ROUND;
                end
            end
            BK_ROUND:
            begin
                v_next   = v_round;
                // Slide the window: word 0 is the current round's schedule word.
                w_next   = {w_new, w_reg[BLOCK_WORDS-1:1]};
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = BK_FINAL;
                end
            end
            BK_FINAL:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || digest_out.ready)
                begin
                    chain_next     = chain_sum;
                    total_next     = total_reg + BLOCK_BYTES;
                    out_chain_next = chain_sum;
                    out_total_next = total_reg + BLOCK_BYTES;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign digest_out.valid            = out_valid_reg;
    assign digest_out.digest_words_0_1 = {out_chain_reg[0], out_chain_reg[1]};
    assign digest_out.digest_words_2_3 = {out_chain_reg[2], out_chain_reg[3]};
    assign digest_out.digest_words_4_5 = {out_chain_reg[4], out_chain_reg[5]};
    assign digest_out.digest_words_6_7 = {out_chain_reg[6], out_chain_reg[7]};
    assign digest_out.bytes_hashed     = out_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rnd_reg       <= '0;
            chain_reg     <= IV_INIT;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            chain_reg     <= chain_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        w_reg         <= w_next;
        out_chain_reg <= out_chain_next;
        out_total_reg <= out_total_next;
    end

endmodule

>>> sv/sha256_block_compress.sv
// SHA-256 block compressor, top level: front, one-entry block queue and back.
// Depends on sbc_pkg, sbc_if.sv, sbc_front, sbc_queue and sbc_back.
//
// Usage: send 32-bit big-endian message words on msg_in, one per beat. Set
// start_message on the first word of a message: the chaining value reloads
// from the init words and the byte count clears (a partial block is dropped).
// Every 16th word of a block produces one beat on digest_out with the new
// chaining value and the count of bytes in whole blocks so far; other words
// produce nothing. The cfg channel writes init words 0..7 (indexes 8 and up
// are ignored) and is always ready; write it only while the block is idle.
// Once the 16th word is accepted, the block is registered in the queue,
// loaded into the back, run through 64 rounds, and the chaining add writes
// the output register. The back works on one block at a time with the
// single round unit doing one round per cycle; the front collects the next
// block meanwhile, and the queue holds it until the back is free.
// Reset: init words and chaining value return to the standard IV, counts
// clear, nothing is pending. When digest_out stalls, the result holds in
// the output register, the next block waits in the back, the queue fills,
// and msg_in drops ready only on the word that would complete another block.
module sha256_block_compress import sbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sbc_msg_if.sink      msg_in,
    sbc_cfg_if.sink      cfg,
    sbc_digest_if.source digest_out
);

    logic   push_valid;
    logic   push_ready;
    block_t push_block;
    logic   pop_valid;
    logic   pop_ready;
    block_t pop_block;

    sbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_in),
        .cfg        (cfg),
        .q_ready    (push_ready),
        .push_valid (push_valid),
        .push_block (push_block)
    );

    sbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_block (push_block),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_block  (pop_block)
    );

    sbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_valid  (pop_valid),
        .blk_ready  (pop_ready),
        .blk        (pop_block),
        .digest_out (digest_out)
    );

endmodule
